/* sv/crdq_pkg.sv */
`default_nettype none
package crdq_pkg;

	localparam int unsigned DEPTH = 8;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef enum logic [0:0] {
		CTRL_IDLE,
		CTRL_RESP
	} ctrl_state_t;

	typedef enum logic [2:0] {
		ACT_NOP,
		ACT_PUSH_FIRST,
		ACT_PUSH_FRONT,
		ACT_PUSH_REAR,
		ACT_POP,
		ACT_POP_LAST
	} act_t;

	typedef struct packed {
		logic       load;
		act_t       act;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic last;
	} dp_stat_t;

	function automatic ptr_t slot_next(input ptr_t s);
		return (s == PTR_W'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic ptr_t slot_prev(input ptr_t s);
		return (s == '0) ? PTR_W'(DEPTH - 1) : s - 1'b1;
	endfunction

endpackage
`default_nettype wire

/* sv/crdq_if.sv */
`default_nettype none
interface crdq_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [31:0] value;

	modport source (output valid, op, value, input ready);
	modport sink (input valid, op, value, output ready);
endinterface

interface crdq_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] popped_value;
	logic [1:0]        status;
	logic              now_empty;
	logic              now_full;

	modport source (output valid, popped_value, status, now_empty, now_full, input ready);
	modport sink (input valid, popped_value, status, now_empty, now_full, output ready);
endinterface
`default_nettype wire

/* sv/circular_deque_front_rear_unit.sv */
// channel | dir | payload                                    | handshake
// req     | in  | op[1:0], value[31:0] signed                | valid/ready
// rsp     | out | popped_value[31:0], status[1:0],           | valid/ready
//         |     | now_empty, now_full                        |
//
// one beat on req gives one beat on rsp in the cycle after, from an output register
// a new req beat is taken in the same cycle as the waiting rsp beat leaves,
// so the unit sustains one operation per cycle while rsp is not stalled; the 8-word ring is in flip-flops
// reset clears pointers and sets the empty flag; ring contents are not cleared
// a stalled rsp holds req off until the rsp beat is taken
`default_nettype none
module circular_deque_front_rear_unit
	import crdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	crdq_req_if.sink  req,
	crdq_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t dp_stat;

	crdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	crdq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (req.value),
		.dp_stat      (dp_stat),
		.popped_value (rsp.popped_value),
		.status       (rsp.status),
		.now_empty    (rsp.now_empty),
		.now_full     (rsp.now_full)
	);

endmodule
`default_nettype wire

/* sv/crdq_ctrl.sv */
`default_nettype none
module crdq_ctrl
	import crdq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic [1:0] req_op,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	input  wire dp_stat_t dp_stat,
	output dp_cmd_t       cmd
);

	ctrl_state_t state_q, state_d;
	logic        take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTRL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		rsp_valid  = 1'b0;
		cmd.load   = 1'b0;
		cmd.act    = ACT_NOP;
		cmd.status = STAT_DONE;

		unique case (state_q)
			CTRL_IDLE: begin
				req_ready = 1'b1;
			end
			CTRL_RESP: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				if (rsp_ready) begin
					state_d = CTRL_IDLE;
				end
			end
			default: begin
				state_d = CTRL_IDLE;
			end
		endcase

		take = req_valid && req_ready;
		if (take) begin
			state_d  = CTRL_RESP;
			cmd.load = 1'b1;
			unique case (req_op) inside
				OP_PUSH_FRONT, OP_PUSH_REAR: begin
					if (dp_stat.full) begin
						cmd.status = STAT_OVERFLOW;
					end else if (dp_stat.empty) begin
						cmd.act = ACT_PUSH_FIRST;
					end else if (req_op == OP_PUSH_FRONT) begin
						cmd.act = ACT_PUSH_FRONT;
					end else begin
						cmd.act = ACT_PUSH_REAR;
					end
				end
				OP_POP_FRONT: begin
					if (dp_stat.empty) begin
						cmd.status = STAT_UNDERFLOW;
					end else if (dp_stat.last) begin
						cmd.act = ACT_POP_LAST;
					end else begin
						cmd.act = ACT_POP;
					end
				end
				default: begin
					cmd.act = ACT_NOP;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/crdq_dp.sv */
`default_nettype none
module crdq_dp
	import crdq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	input  wire logic signed [31:0]  value,
	output dp_stat_t                 dp_stat,
	output logic signed [31:0]       popped_value,
	output logic [1:0]               status,
	output logic                     now_empty,
	output logic                     now_full
);

	logic [DATA_W-1:0] ring_q [DEPTH];
	ptr_t              front_q, rear_q, front_d, rear_d, wr_slot;
	logic              empty_q, empty_d, wr_en;
	logic [DATA_W-1:0] pop_d;
	logic signed [31:0] popped_q;
	logic [1:0]        status_q;
	logic              now_empty_q, now_full_q;

	assign dp_stat.empty = empty_q;
	assign dp_stat.full  = !empty_q && (slot_next(rear_q) == front_q);
	assign dp_stat.last  = (front_q == rear_q);

	always_comb begin
		front_d = front_q;
		rear_d  = rear_q;
		empty_d = empty_q;
		wr_en   = 1'b0;
		wr_slot = front_q;
		pop_d   = '0;
		unique case (cmd.act)
			ACT_PUSH_FIRST: begin
				front_d = '0;
				rear_d  = '0;
				empty_d = 1'b0;
				wr_en   = 1'b1;
				wr_slot = '0;
			end
			ACT_PUSH_FRONT: begin
				front_d = slot_prev(front_q);
				wr_en   = 1'b1;
				wr_slot = front_d;
			end
			ACT_PUSH_REAR: begin
				rear_d  = slot_next(rear_q);
				wr_en   = 1'b1;
				wr_slot = rear_d;
			end
			ACT_POP: begin
				pop_d   = ring_q[front_q];
				front_d = slot_next(front_q);
			end
			ACT_POP_LAST: begin
				pop_d   = ring_q[front_q];
				front_d = '0;
				rear_d  = '0;
				empty_d = 1'b1;
			end
			default: begin
				pop_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.load) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wr_en) begin
			ring_q[wr_slot] <= value;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			popped_q    <= pop_d;
			status_q    <= cmd.status;
			now_empty_q <= empty_d;
			now_full_q  <= !empty_d && (slot_next(rear_d) == front_d);
		end
	end

	assign popped_value = popped_q;
	assign status       = status_q;
	assign now_empty    = now_empty_q;
	assign now_full     = now_full_q;

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
module tb;
	import crdq_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned PHASE_LEN = 120;
	localparam int unsigned DIRECTED_OPS = 22;
	localparam int unsigned TOTAL_OPS = DIRECTED_OPS + 1950;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] value;
		int unsigned phase;
		bit          hold;
		bit          drain;
	} deque_op_t;

	typedef struct packed {
		logic [31:0] popped_value;
		logic [1:0]  status;
		logic        now_empty;
		logic        now_full;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n;

	crdq_req_if req_ch();
	crdq_rsp_if rsp_ch();

	circular_deque_front_rear_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	deque_op_t     op_queue[$];
	deque_result_t due_results[$];

	logic [31:0] ring_words[DEPTH];
	ptr_t        front_slot;
	ptr_t        rear_slot;
	bit          deque_empty;

	logic [31:0] edge_words[4] = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000};
	int unsigned send_idle_pct[4] = '{0, 65, 0, 6};
	int unsigned recv_stall_pct[4] = '{0, 0, 65, 6};

	int unsigned cur_phase;
	logic        hold_go;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int unsigned errors;
	int unsigned n_checked, n_push, n_pop, n_over, n_under, n_nop, n_filled, n_emptied;

	always #5 clk = ~clk;

	function automatic ptr_t ring_after(input ptr_t s);
		return (s == ptr_t'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic bit ring_full();
		return !deque_empty && (ring_after(rear_slot) == front_slot);
	endfunction

	// next-state and response of the deque for one accepted request beat
	function automatic void deque_step(input logic [1:0] op, input logic [31:0] value);
		deque_result_t r;
		r = '{32'h0, STAT_DONE, 1'b0, 1'b0};
		if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
			if (ring_full()) begin
				r.status = STAT_OVERFLOW;
				n_over++;
			end else begin
				n_push++;
				if (deque_empty) begin
					front_slot = '0;
					rear_slot = '0;
					deque_empty = 1'b0;
					ring_words[0] = value;
				end else if (op == OP_PUSH_FRONT) begin
					front_slot = (front_slot == '0) ? ptr_t'(DEPTH - 1) : front_slot - 1'b1;
					ring_words[front_slot] = value;
				end else begin
					rear_slot = ring_after(rear_slot);
					ring_words[rear_slot] = value;
				end
				if (ring_full())
					n_filled++;
			end
		end else if (op == OP_POP_FRONT) begin
			if (deque_empty) begin
				r.status = STAT_UNDERFLOW;
				n_under++;
			end else begin
				n_pop++;
				r.popped_value = ring_words[front_slot];
				if (front_slot == rear_slot) begin
					deque_empty = 1'b1;
					front_slot = '0;
					rear_slot = '0;
					n_emptied++;
				end else begin
					front_slot = ring_after(front_slot);
				end
			end
		end else begin
			n_nop++;
		end
		r.now_empty = deque_empty;
		r.now_full = ring_full();
		due_results.push_back(r);
	endfunction

	task automatic add_op(input logic [1:0] op, input logic [31:0] value);
		deque_op_t it;
		it.op = op;
		it.value = value;
		it.phase = (op_queue.size() / PHASE_LEN) % 4;
		it.hold = (op_queue.size() == 100 || op_queue.size() == 540);
		it.drain = (op_queue.size() % 400 == DIRECTED_OPS);
		op_queue.push_back(it);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		deque_op_t nxt;
		bit        offer;
		bit        hold_now;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= OP_PUSH_FRONT;
			req_ch.value <= '0;
			hold_go <= 1'b0;
		end else begin
			hold_now = 1'b0;
			if (req_ch.valid && req_ch.ready)
				deque_step(req_ch.op, req_ch.value);
			if (!(req_ch.valid && !req_ch.ready)) begin
				offer = 1'b0;
				if (op_queue.size() != 0) begin
					nxt = op_queue[0];
					offer = ($urandom_range(99) >= send_idle_pct[nxt.phase])
						&& (!nxt.drain || due_results.size() == 0);
				end
				if (offer) begin
					void'(op_queue.pop_front());
					req_ch.valid <= 1'b1;
					req_ch.op <= nxt.op;
					req_ch.value <= nxt.value;
					cur_phase <= nxt.phase;
					hold_now = nxt.hold;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			hold_go <= hold_now;
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		deque_result_t got;
		deque_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.popped_value, rsp_ch.status, rsp_ch.now_empty, rsp_ch.now_full};
				n_checked++;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t unexpected beat: value %h status %0d empty %b full %b",
						$time, got.popped_value, got.status, got.now_empty, got.now_full);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t mismatch: exp value %h status %0d empty %b full %b",
							$time, want.popped_value, want.status, want.now_empty,
							want.now_full);
						$display("%0t          got value %h status %0d empty %b full %b",
							$time, got.popped_value, got.status, got.now_empty,
							got.now_full);
					end
				end
			end
			rsp_ch.ready <= (hold_left == 0)
				&& ($urandom_range(99) >= recv_stall_pct[cur_phase]);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int unsigned mode;
		int unsigned run;
		int unsigned push_pct;
		logic [1:0]  op;
		logic [31:0] word;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH_FRONT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		front_slot = '0;
		rear_slot = '0;
		deque_empty = 1'b1;
		cur_phase = 0;
		errors = 0;

		// underflow and no-op on empty, fill to full with wrap at the front
		add_op(OP_POP_FRONT, 32'h1111_1111);
		add_op(OP_NONE, 32'hffff_ffff);
		add_op(OP_PUSH_REAR, 32'h7fff_ffff);
		add_op(OP_PUSH_FRONT, 32'h8000_0000);
		add_op(OP_PUSH_REAR, 32'hffff_ffff);
		add_op(OP_PUSH_FRONT, 32'h0000_0000);
		add_op(OP_PUSH_REAR, 32'h0000_0001);
		add_op(OP_PUSH_FRONT, 32'haaaa_aaaa);
		add_op(OP_PUSH_REAR, 32'h5555_5555);
		add_op(OP_PUSH_FRONT, 32'h1234_5678);
		// overflow both ways and no-op while full
		add_op(OP_PUSH_REAR, 32'hdead_beef);
		add_op(OP_PUSH_FRONT, 32'hcafe_f00d);
		add_op(OP_NONE, 32'h0);
		// drain to empty, then one more pop
		for (int k = 0; k < 9; k++)
			add_op(OP_POP_FRONT, $urandom);

		while (op_queue.size() < TOTAL_OPS) begin
			mode = $urandom_range(2);
			run = $urandom_range(48, 8);
			case (mode)
				0: push_pct = 75;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			for (int k = 0; k < run; k++) begin
				word = ($urandom_range(7) == 0) ? edge_words[$urandom_range(3)] : $urandom;
				if ($urandom_range(99) < 3)
					op = OP_NONE;
				else if ($urandom_range(99) < push_pct)
					op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
				else
					op = OP_POP_FRONT;
				add_op(op, word);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d results checked: %0d pushes, %0d pops, %0d overflows, %0d underflows",
			n_checked, n_push, n_pop, n_over, n_under);
		$display("%0d no-ops, ring filled %0d times and emptied by pop %0d times",
			n_nop, n_filled, n_emptied);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
